FILE: sv/w2d_pkg.sv
// Shared types and constants for the wide integer to decimal text block.
// Used by w2d_cell and wide_integer_to_decimal_text; depends on nothing.
package w2d_pkg;

	localparam int NUM_CELLS   = 78;
	localparam int MAX_RESULTS = 42;

	typedef logic [2:0] cell_mode_t;
	localparam cell_mode_t MODE_HOLD = 3'd0;
	localparam cell_mode_t MODE_CLR  = 3'd1;
	localparam cell_mode_t MODE_DAB  = 3'd2;
	localparam cell_mode_t MODE_ROT  = 3'd3;
	localparam cell_mode_t MODE_UP   = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       signed_mode;
		logic [7:0] decimals;
	} in_t;

	typedef struct packed {
		logic [63:0] char_pack;
		logic [3:0]  char_count;
		logic        last_out;
	} out_t;

endpackage

FILE: sv/w2d_cell.sv
// One BCD digit cell of the conversion chain: clear, add-3 and shift, rotate, shift up.
// Depends on w2d_pkg.
module w2d_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  w2d_pkg::cell_mode_t mode,
	input  logic                bit_in,
	input  logic [3:0]          dn_in,
	input  logic [3:0]          up_in,
	output logic [3:0]          digit,
	output logic                bit_out
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[3];
	assign digit   = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			unique case (mode)
				w2d_pkg::MODE_CLR: digit_q <= '0;
				w2d_pkg::MODE_DAB: digit_q <= {adj[2:0], bit_in};
				w2d_pkg::MODE_ROT: digit_q <= up_in;
				w2d_pkg::MODE_UP:  digit_q <= dn_in;
				default:           digit_q <= digit_q;
			endcase
		end
	end

endmodule

FILE: sv/wide_integer_to_decimal_text.sv
// Top level: byte loader, sign handling, digit chain and text sequencer.
// Depends on w2d_pkg and w2d_cell.
//
// Bytes are taken one per cycle while busy is low. The byte with last_byte
// starts a conversion: add-3 and shift through a chain of 78 digit cells,
// a rotation of the chain that finds the digit count and the trailing zeros,
// a shift that moves the top digit to the chain's end, a setup step, then one
// text character per cycle. Results leave on strobe for one cycle each and
// cannot be held off; busy stays high until the last result is out.
module wide_integer_to_decimal_text #(
	parameter int WORD_BYTES       = 32,
	parameter int MAX_DIGITS       = 78,
	parameter int CHARS_PER_RESULT = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  w2d_pkg::in_t   request,
	output logic           busy,
	output logic           strobe,
	output w2d_pkg::out_t  result
);

	localparam int W  = WORD_BYTES * 8;
	localparam int NC = w2d_pkg::NUM_CELLS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CONV  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_NORM  = 3'd3;
	localparam logic [2:0] S_SETUP = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0]   state_q;
	logic [W-1:0] sh_q, bin_q;
	logic [W+7:0] sh_cat;
	logic [W-1:0] sh_new;
	logic [8:0]   cnt_q;
	logic         sgn_q, neg_q, seen_q, err_q, sign_q, lead0_q, dot_q;
	logic [7:0]   dec_q;
	logic [6:0]   hi_q, tz_q;
	logic [8:0]   int_q, zpad_q, frac_q, len_q, emit_q;
	logic [2:0]   fill_q;
	logic [5:0]   res_q;
	logic [63:0]  pack_q;
	logic         strobe_q;
	w2d_pkg::out_t result_q;

	w2d_pkg::cell_mode_t mode;
	logic [3:0] dig   [NC];
	logic       bout  [NC];

	logic [8:0] n9, d9, tz9, ip9, fl9, sig9, zp9;
	logic [6:0] n_w;
	logic [3:0] cell0;
	logic [7:0] ch;
	logic       take_digit, last_char, flush, final_res;
	logic [63:0] pack_next;

	assign sh_cat = {sh_q, request.data_byte};
	assign sh_new = sh_cat[W-1:0];
	assign cell0  = dig[0];
	assign n_w    = seen_q ? hi_q + 7'd1 : 7'd1;
	assign n9     = {2'b0, n_w};
	assign d9     = {1'b0, dec_q};
	assign tz9    = {2'b0, tz_q};
	assign ip9    = n9 - d9;
	assign fl9    = (d9 > tz9) ? d9 - tz9 : 9'd0;
	assign sig9   = seen_q ? n9 - tz9 : 9'd0;
	assign zp9    = d9 - n9;

	genvar g;
	generate
		for (g = 0; g < NC; g++) begin : g_cell
			w2d_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.mode   (mode),
				.bit_in ((g == 0) ? bin_q[W-1] : bout[(g == 0) ? 0 : g - 1]),
				.dn_in  ((g == 0) ? 4'd0 : dig[(g == 0) ? 0 : g - 1]),
				.up_in  (dig[(g + 1) % NC]),
				.digit  (dig[g]),
				.bit_out(bout[g])
			);
		end
	endgenerate

	always_comb begin
		take_digit = 1'b0;
		ch         = w2d_pkg::CH_ZERO;
		priority if (err_q) begin
			ch = (emit_q == 9'd0) ? w2d_pkg::CH_E : w2d_pkg::CH_R;
		end else if (sign_q) begin
			ch = w2d_pkg::CH_MINUS;
		end else if (lead0_q) begin
			ch = w2d_pkg::CH_ZERO;
		end else if (int_q != 9'd0) begin
			ch         = w2d_pkg::CH_ZERO | {4'd0, dig[NC-1]};
			take_digit = 1'b1;
		end else if (dot_q) begin
			ch = w2d_pkg::CH_DOT;
		end else if (zpad_q != 9'd0) begin
			ch = w2d_pkg::CH_ZERO;
		end else begin
			ch         = w2d_pkg::CH_ZERO | {4'd0, dig[NC-1]};
			take_digit = 1'b1;
		end
		last_char = (emit_q + 9'd1) == len_q;
		flush     = last_char || (fill_q == 3'(CHARS_PER_RESULT - 1));
		final_res = last_char || (res_q == 6'(w2d_pkg::MAX_RESULTS - 1));
		pack_next = (fill_q == 3'd0) ? 64'd0 : pack_q;
		for (int j = 0; j < 8; j++) begin
			if (j < CHARS_PER_RESULT && fill_q == 3'(j)) pack_next[j*8 +: 8] = ch;
		end
	end

	always_comb begin
		mode = w2d_pkg::MODE_HOLD;
		unique case (state_q)
			S_IDLE:  if (start && request.last_byte) mode = w2d_pkg::MODE_CLR;
			S_CONV:  mode = w2d_pkg::MODE_DAB;
			S_SCAN:  mode = w2d_pkg::MODE_ROT;
			S_NORM:  if (cnt_q != 9'(NC) - n9) mode = w2d_pkg::MODE_UP;
			S_EMIT:  if (take_digit && !err_q) mode = w2d_pkg::MODE_UP;
			default: mode = w2d_pkg::MODE_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sh_q     <= '0;
			bin_q    <= '0;
			cnt_q    <= '0;
			sgn_q    <= 1'b0;
			neg_q    <= 1'b0;
			seen_q   <= 1'b0;
			err_q    <= 1'b0;
			sign_q   <= 1'b0;
			lead0_q  <= 1'b0;
			dot_q    <= 1'b0;
			dec_q    <= '0;
			hi_q     <= '0;
			tz_q     <= '0;
			int_q    <= '0;
			zpad_q   <= '0;
			frac_q   <= '0;
			len_q    <= '0;
			pack_q   <= '0;
			result_q <= '0;
			strobe_q <= 1'b0;
			fill_q   <= '0;
			res_q    <= '0;
			emit_q   <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (request.last_byte) begin
							sh_q    <= '0;
							sgn_q   <= request.signed_mode;
							dec_q   <= request.decimals;
							neg_q   <= request.signed_mode & sh_new[W-1];
							bin_q   <= (request.signed_mode & sh_new[W-1]) ?
								~sh_new + W'(1) : sh_new;
							cnt_q   <= '0;
							state_q <= S_CONV;
						end else begin
							sh_q <= sh_new;
						end
					end
				end
				S_CONV: begin
					bin_q <= bin_q << 1;
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'(W - 1)) begin
						cnt_q   <= '0;
						seen_q  <= 1'b0;
						hi_q    <= '0;
						tz_q    <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cell0 != 4'd0) begin
						hi_q   <= cnt_q[6:0];
						seen_q <= 1'b1;
					end else if (!seen_q) begin
						tz_q <= tz_q + 7'd1;
					end
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'(NC - 1)) begin
						cnt_q   <= '0;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (cnt_q == 9'(NC) - n9) state_q <= S_SETUP;
					else cnt_q <= cnt_q + 9'd1;
				end
				S_SETUP: begin
					err_q   <= n9 > 9'(MAX_DIGITS);
					sign_q  <= 1'b0;
					lead0_q <= 1'b0;
					dot_q   <= 1'b0;
					int_q   <= '0;
					zpad_q  <= '0;
					frac_q  <= '0;
					emit_q  <= '0;
					fill_q  <= '0;
					res_q   <= '0;
					state_q <= S_EMIT;
					priority if (n9 > 9'(MAX_DIGITS)) begin
						len_q <= 9'd3;
					end else if (sgn_q || dec_q == 8'd0) begin
						sign_q <= neg_q;
						int_q  <= n9;
						len_q  <= n9 + {8'd0, neg_q};
					end else if (n9 > d9) begin
						int_q  <= ip9;
						dot_q  <= fl9 != 9'd0;
						frac_q <= fl9;
						len_q  <= ip9 + fl9 + {8'd0, fl9 != 9'd0};
					end else begin
						lead0_q <= 1'b1;
						dot_q   <= sig9 != 9'd0;
						zpad_q  <= (sig9 != 9'd0) ? zp9 : 9'd0;
						frac_q  <= sig9;
						len_q   <= (sig9 != 9'd0) ? 9'd2 + zp9 + sig9 : 9'd1;
					end
				end
				S_EMIT: begin
					emit_q <= emit_q + 9'd1;
					priority if (err_q) begin
					end else if (sign_q) begin
						sign_q <= 1'b0;
					end else if (lead0_q) begin
						lead0_q <= 1'b0;
					end else if (int_q != 9'd0) begin
						int_q <= int_q - 9'd1;
					end else if (dot_q) begin
						dot_q <= 1'b0;
					end else if (zpad_q != 9'd0) begin
						zpad_q <= zpad_q - 9'd1;
					end else begin
						frac_q <= frac_q - 9'd1;
					end
					pack_q <= pack_next;
					if (flush) begin
						fill_q              <= '0;
						res_q               <= res_q + 6'd1;
						strobe_q            <= 1'b1;
						result_q.char_pack  <= pack_next;
						result_q.char_count <= {1'b0, fill_q} + 4'd1;
						result_q.last_out   <= final_res;
						if (final_res) state_q <= S_IDLE;
					end else begin
						fill_q <= fill_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule
